FILE: src/touch_report_frame_parser_defines.svh
// assertion macros for the touch report frame parser
// used by src/touch_report_frame_parser.sv; no other dependencies
`ifndef TOUCH_REPORT_FRAME_PARSER_DEFINES_SVH
`define TOUCH_REPORT_FRAME_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
`define TFP_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("tfp assertion failed");
`define TFP_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("tfp assertion failed");
`else
`define TFP_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons)
`define TFP_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif

`endif

FILE: src/tfp_pkg.sv
// shared constants and types for the touch report frame parser
// no dependencies
`default_nettype none

package tfp_pkg;

    localparam logic [7:0] HDR_BYTE     = 8'hAA;
    localparam logic [7:0] STAT_TOUCH   = 8'h73;
    localparam logic [7:0] STAT_RELEASE = 8'h72;

    typedef enum logic [3:0] {
        POS_TRAIL_LAST = 4'd1,
        POS_TRAIL_3    = 4'd2,
        POS_TRAIL_2    = 4'd3,
        POS_TRAIL_1    = 4'd4,
        POS_Y_LOW      = 4'd5,
        POS_Y_HIGH     = 4'd6,
        POS_X_LOW      = 4'd7,
        POS_X_HIGH     = 4'd8,
        POS_STATUS     = 4'd9,
        POS_HUNT       = 4'd10
    } pos_t;

endpackage

`default_nettype wire

FILE: src/touch_report_frame_parser.sv
// touch report frame parser: parses ten-byte touch panel reports byte by byte
// depends on tfp_pkg and touch_report_frame_parser_defines.svh
//
// One result transaction per received byte, carrying the published touch status,
// the latched x and y coordinates and a frame-done mark for the y-low byte.
// A byte is taken in the cycle it is offered, one byte per clock, whenever the
// result register is empty or is being drained in the same cycle; the result
// appears in the cycle after the byte is taken. Frames start with header 0xAA;
// status 0x73 marks a pending touch, 0x72 clears pending and published status.
`default_nettype none
`include "touch_report_frame_parser_defines.svh"

module touch_report_frame_parser
    import tfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             touched,
    output logic [15:0]      x_coord,
    output logic [15:0]      y_coord,
    output logic             frame_done,
    output logic             out_valid,
    input  wire logic        out_ready
);

    pos_t        pos_reg, pos_next;
    logic        pending_reg, pending_next;
    logic        touched_status_reg, touched_status_next;
    logic [7:0]  x_high_reg, x_high_next;
    logic [7:0]  x_low_reg, x_low_next;
    logic [7:0]  y_high_reg, y_high_next;
    logic [7:0]  y_low_reg, y_low_next;
    logic        done_next;

    logic        out_valid_reg;
    logic        touched_out_reg;
    logic [15:0] x_out_reg;
    logic [15:0] y_out_reg;
    logic        done_out_reg;

    logic        in_accept;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        pos_next            = pos_reg;
        pending_next        = pending_reg;
        touched_status_next = touched_status_reg;
        x_high_next         = x_high_reg;
        x_low_next          = x_low_reg;
        y_high_next         = y_high_reg;
        y_low_next          = y_low_reg;
        done_next           = 1'b0;
        unique case (pos_reg)
            POS_HUNT:
            begin
                if (rx_byte == HDR_BYTE)
                begin
                    pos_next = POS_STATUS;
                end
                else
                begin
                    pending_next = 1'b0;
                end
            end
            POS_STATUS:
            begin
                if (rx_byte == STAT_TOUCH)
                begin
                    pending_next = 1'b1;
                end
                else if (rx_byte == STAT_RELEASE)
                begin
                    pending_next        = 1'b0;
                    touched_status_next = 1'b0;
                end
                pos_next = POS_X_HIGH;
            end
            POS_X_HIGH:
            begin
                x_high_next = rx_byte;
                pos_next    = POS_X_LOW;
            end
            POS_X_LOW:
            begin
                x_low_next = rx_byte;
                pos_next   = POS_Y_HIGH;
            end
            POS_Y_HIGH:
            begin
                y_high_next = rx_byte;
                pos_next    = POS_Y_LOW;
            end
            POS_Y_LOW:
            begin
                y_low_next          = rx_byte;
                touched_status_next = pending_reg;
                done_next           = 1'b1;
                pos_next            = POS_TRAIL_1;
            end
            POS_TRAIL_1:    pos_next = POS_TRAIL_2;
            POS_TRAIL_2:    pos_next = POS_TRAIL_3;
            POS_TRAIL_3:    pos_next = POS_TRAIL_LAST;
            POS_TRAIL_LAST: pos_next = POS_HUNT;
            default:
            begin
                pos_next     = POS_HUNT;
                pending_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg            <= POS_HUNT;
            pending_reg        <= 1'b0;
            touched_status_reg <= 1'b0;
            x_high_reg         <= 8'd0;
            x_low_reg          <= 8'd0;
            y_high_reg         <= 8'd0;
            y_low_reg          <= 8'd0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                pos_reg            <= pos_next;
                pending_reg        <= pending_next;
                touched_status_reg <= touched_status_next;
                x_high_reg         <= x_high_next;
                x_low_reg          <= x_low_next;
                y_high_reg         <= y_high_next;
                y_low_reg          <= y_low_next;
                out_valid_reg      <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            touched_out_reg <= touched_status_next;
            x_out_reg       <= {x_high_next, x_low_next};
            y_out_reg       <= {y_high_next, y_low_next};
            done_out_reg    <= done_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign touched    = touched_out_reg;
    assign x_coord    = x_out_reg;
    assign y_coord    = y_out_reg;
    assign frame_done = done_out_reg;

    `TFP_ASSERT_SAME(a_done_after_y_low, clk, rst_n,
        out_valid_reg && done_out_reg, pos_reg == POS_TRAIL_1)
    `TFP_ASSERT_NEXT(a_bad_header_clears, clk, rst_n,
        in_accept && pos_reg == POS_HUNT && rx_byte != HDR_BYTE, !pending_reg)
    `TFP_ASSERT_NEXT(a_release_clears, clk, rst_n,
        in_accept && pos_reg == POS_STATUS && rx_byte == STAT_RELEASE,
        !pending_reg && !touched_status_reg)
    `TFP_ASSERT_SAME(a_result_matches_state, clk, rst_n,
        out_valid_reg, touched_out_reg == touched_status_reg
        && x_out_reg == {x_high_reg, x_low_reg} && y_out_reg == {y_high_reg, y_low_reg})

endmodule

`default_nettype wire
